/* src/fpalu_pkg.sv */
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpalu_pkg;

  // Default number of fraction bits in a Q value
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Operation codes
  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_INC      = 4'd4,
    ACT_DEC      = 4'd5,
    ACT_MIN      = 4'd6,
    ACT_MAX      = 4'd7,
    ACT_TO_INT   = 4'd8,
    ACT_FROM_INT = 4'd9
  } action_t;

  // One input transaction
  typedef struct packed {
    logic        [3:0]  action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic signed [31:0] result;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               divide_by_zero;
  } out_t;

endpackage

/* src/fixed_point_alu.sv */
// Pipelined signed fixed-point ALU with a one-bit-per-stage restoring divider.
// Throughput: one transaction per cycle, every cycle; busy is never raised and
//   the receiver cannot hold results off.
// Stages: input, operand, 32 + FRAC_BITS divider stages and output, all registered;
//   out_valid and the result come from the output register.
// Reset (rst_n low, synchronous) clears all valid bits; no results follow it.
module fixed_point_alu
  import fpalu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // Dividend width: |a| shifted left by the fraction bits
  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned LAT = NW + 3;

  // Operand stage payload
  typedef struct packed {
    logic signed [31:0] res;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               is_mul;
    logic               is_div;
    logic               dz;
    logic               neg;
    logic signed [63:0] prod;
    logic [NW-1:0]      dvd;
    logic [31:0]        dsr;
  } op_stage_t;

  // Divider stage payload
  typedef struct packed {
    logic signed [31:0] res;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               is_div;
    logic               dz;
    logic               neg;
    logic [31:0]        rem;
    logic [NW-1:0]      dvd;
    logic [31:0]        dsr;
  } div_stage_t;

  logic            s0_vld_r;
  in_t             s0_r;
  logic            s1_vld_r;
  op_stage_t       s1_nxt;
  op_stage_t       s1_r;
  div_stage_t      dv_in0;
  div_stage_t      stg_in  [NW];
  div_stage_t      dv_nxt  [NW];
  div_stage_t      dv_r    [NW];
  logic [NW-1:0]   dv_vld_r;
  out_t            out_nxt;
  logic            out_vld_r;
  out_t            out_r;

  // Never stall the input
  assign busy = 1'b0;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      dv_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= start && !busy;
      s1_vld_r  <= s0_vld_r;
      dv_vld_r  <= {dv_vld_r[NW-2:0], s1_vld_r};
      out_vld_r <= dv_vld_r[NW-1];
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_r <= in_data;
    end
  end

  // Operand stage: simple results, flags, product and divider setup
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    a     = s0_r.operand_a;
    b     = s0_r.operand_b;
    mag_a = a[31] ? (32'd0 - a) : a;
    mag_b = b[31] ? (32'd0 - b) : b;
    s1_nxt        = '0;
    s1_nxt.lt     = a < b;
    s1_nxt.eq     = a == b;
    s1_nxt.gt     = a > b;
    s1_nxt.is_mul = s0_r.action == ACT_MUL;
    s1_nxt.is_div = s0_r.action == ACT_DIV;
    s1_nxt.dz     = (s0_r.action == ACT_DIV) && (b == 32'sd0);
    s1_nxt.neg    = a[31] ^ b[31];
    s1_nxt.prod   = 64'(a) * 64'(b);
    s1_nxt.dvd    = {mag_a, {FRAC_BITS{1'b0}}};
    s1_nxt.dsr    = mag_b;
    case (s0_r.action)
      ACT_ADD:      s1_nxt.res = a + b;
      ACT_SUB:      s1_nxt.res = a - b;
      ACT_INC:      s1_nxt.res = a + 32'sd1;
      ACT_DEC:      s1_nxt.res = a - 32'sd1;
      ACT_MIN:      s1_nxt.res = (a < b) ? a : b;
      ACT_MAX:      s1_nxt.res = (a > b) ? a : b;
      ACT_TO_INT:   s1_nxt.res = a >>> FRAC_BITS;
      ACT_FROM_INT: s1_nxt.res = a << FRAC_BITS;
      default:      s1_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // Merge the scaled product and start the divider
  always_comb begin
    dv_in0        = '0;
    dv_in0.res    = s1_r.is_mul ? s1_r.prod[FRAC_BITS +: 32] : s1_r.res;
    dv_in0.lt     = s1_r.lt;
    dv_in0.eq     = s1_r.eq;
    dv_in0.gt     = s1_r.gt;
    dv_in0.is_div = s1_r.is_div;
    dv_in0.dz     = s1_r.dz;
    dv_in0.neg    = s1_r.neg;
    dv_in0.rem    = '0;
    dv_in0.dvd    = s1_r.dvd;
    dv_in0.dsr    = s1_r.dsr;
  end

  // Divider chain: one restoring step per stage, MSB first
  for (genvar k = 0; k < NW; k++) begin : g_div
    if (k == 0) begin : g_first
      assign stg_in[k] = dv_in0;
    end else begin : g_next
      assign stg_in[k] = dv_r[k-1];
    end

    always_comb begin
      logic [32:0] trial;
      logic [32:0] diff;
      logic        ge;
      trial     = {stg_in[k].rem, stg_in[k].dvd[NW-1]};
      diff      = trial - {1'b0, stg_in[k].dsr};
      ge        = !diff[32];
      dv_nxt[k]     = stg_in[k];
      dv_nxt[k].rem = ge ? diff[31:0] : trial[31:0];
      dv_nxt[k].dvd = {stg_in[k].dvd[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      dv_r[k] <= dv_nxt[k];
    end
  end

  // Output stage: sign the quotient and drop it on divide by zero
  always_comb begin
    logic [31:0] q;
    q = dv_r[NW-1].dvd[31:0];
    out_nxt.is_less        = dv_r[NW-1].lt;
    out_nxt.is_equal       = dv_r[NW-1].eq;
    out_nxt.is_greater     = dv_r[NW-1].gt;
    out_nxt.divide_by_zero = dv_r[NW-1].dz;
    if (dv_r[NW-1].is_div) begin
      if (dv_r[NW-1].dz) begin
        out_nxt.result = '0;
      end else begin
        out_nxt.result = dv_r[NW-1].neg ? (32'd0 - q) : q;
      end
    end else begin
      out_nxt.result = dv_r[NW-1].res;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every accepted transaction yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing after accepted transaction");

  // Exactly one compare flag per result
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.is_less, out_data.is_equal, out_data.is_greater}))
    else $error("compare flags not one-hot");

  // Divide by zero forces a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero) |-> (out_data.result == 32'sd0))
    else $error("nonzero result on divide by zero");
`endif

endmodule

/* verif/fixed_point_alu_tb.sv */
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps

module fixed_point_alu_tb;
  import fpalu_pkg::*;

  localparam int unsigned FRAC       = FRAC_BITS_DEF;
  localparam int unsigned LATENCY    = FRAC + 35;
  localparam int          N_RANDOM   = 1950;
  localparam int          MAX_LOGGED = 60;

  // Opcodes the block leaves undefined
  localparam logic [3:0] ACT_UNDEF_LO = 4'd10;
  localparam logic [3:0] ACT_UNDEF_HI = 4'd15;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // Predict each ALU transaction and match the results in order
  class alu_scoreboard;
    out_t awaited_results[$];
    int   fails;

    function new();
      fails = 0;
    endfunction

    task flag_mismatch(input string msg);
      fails++;
      // Keep the log short when the block is badly broken
      if (fails <= MAX_LOGGED) $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    function out_t alu_outcome(input in_t t);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] wide;
      out_t r;
      a    = t.operand_a;
      b    = t.operand_b;
      wide = '0;
      r    = '0;
      case (t.action)
        ACT_ADD:      wide = a + b;
        ACT_SUB:      wide = a - b;
        ACT_MUL:      wide = (a * b) >>> FRAC;
        ACT_DIV: begin
          // Truncate toward zero; a zero divisor yields zero and the error flag
          if (b == 0) r.divide_by_zero = 1'b1;
          else wide = (a <<< FRAC) / b;
        end
        ACT_INC:      wide = a + 1;
        ACT_DEC:      wide = a - 1;
        ACT_MIN:      wide = (a < b) ? a : b;
        ACT_MAX:      wide = (a > b) ? a : b;
        ACT_TO_INT:   wide = a >>> FRAC;
        ACT_FROM_INT: wide = a <<< FRAC;
        default:      wide = '0;
      endcase
      r.result     = wide[31:0];
      r.is_less    = (a < b);
      r.is_equal   = (a == b);
      r.is_greater = (a > b);
      return r;
    endfunction

    function void note_input(input in_t t);
      awaited_results.push_back(alu_outcome(t));
    endfunction

    task check_result(input out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with no transaction outstanding", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.result !== want.result)
        flag_mismatch($sformatf("result %h, expected %h", got.result, want.result));
      if (got.is_less !== want.is_less)
        flag_mismatch($sformatf("is_less %b, expected %b", got.is_less, want.is_less));
      if (got.is_equal !== want.is_equal)
        flag_mismatch($sformatf("is_equal %b, expected %b", got.is_equal, want.is_equal));
      if (got.is_greater !== want.is_greater)
        flag_mismatch($sformatf("is_greater %b, expected %b",
                                got.is_greater, want.is_greater));
      if (got.divide_by_zero !== want.divide_by_zero)
        flag_mismatch($sformatf("divide_by_zero %b, expected %b",
                                got.divide_by_zero, want.divide_by_zero));
    endtask

    function int awaited_count();
      return awaited_results.size();
    endfunction
  endclass

  alu_scoreboard sb;

  fixed_point_alu #(
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_op(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b);
    in_t item;
    item.action    = act;
    item.operand_a = a;
    item.operand_b = b;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for the given number of cycles, with junk on the data bus
  task automatic idle_for(input int cycles);
    logic [95:0] junk;
    junk = {$urandom(), $urandom(), $urandom()};
    @(negedge clk);
    start   <= 1'b0;
    in_data <= junk[$bits(in_t)-1:0];
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off until every expected result is back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (sb.awaited_count() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hffff_ffff;
          5: v = 32'h0000_0100;
          default: v = 32'hffff_ff00;
        endcase
      end
      1: v = $urandom_range(0, 1023);
      2: v = -$urandom_range(1, 1023);
      3, 4: v = $urandom();
      5: v = $signed($urandom()) >>> $urandom_range(0, 31);
      default: v = ($urandom_range(0, 4000) - 2000) * 256 + $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_partner(input logic [31:0] a);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = a;
      1: v = a + 1;
      2: v = a - 1;
      3: v = '0;
      default: v = rand_operand();
    endcase
    return v;
  endfunction

  // Run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    logic [3:0]  act;
    logic [31:0] a;
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: wrap points, rounding, zero divisor, ties, undefined codes
    send_op(ACT_ADD,      32'h7fff_ffff, 32'h0000_0001);
    send_op(ACT_SUB,      32'h8000_0000, 32'h0000_0001);
    send_op(ACT_MUL,      32'h7fff_ffff, 32'h7fff_ffff);
    send_op(ACT_MUL,      32'hffff_ffff, 32'h0000_0001);
    send_op(ACT_MUL,      32'h8000_0000, 32'h8000_0000);
    send_op(ACT_MUL,      32'h0000_0180, 32'hffff_fe80);
    send_op(ACT_DIV,      32'h0000_1234, 32'h0000_0000);
    send_op(ACT_DIV,      32'h8000_0000, 32'hffff_ffff);
    send_op(ACT_DIV,      32'h7fff_ffff, 32'h0000_0001);
    send_op(ACT_DIV,      32'hffff_fd00, 32'h0000_0200);
    send_op(ACT_DIV,      32'h0000_0001, 32'hffff_fd00);
    send_op(ACT_INC,      32'h7fff_ffff, 32'h0000_0000);
    send_op(ACT_DEC,      32'h8000_0000, 32'h0000_0000);
    send_op(ACT_MIN,      32'h0000_0500, 32'h0000_0500);
    send_op(ACT_MAX,      32'hffff_fb00, 32'hffff_fb00);
    send_op(ACT_MIN,      32'h8000_0000, 32'h7fff_ffff);
    send_op(ACT_MAX,      32'h8000_0000, 32'h7fff_ffff);
    send_op(ACT_TO_INT,   32'hffff_ffff, 32'h1234_5678);
    send_op(ACT_TO_INT,   32'h8000_0000, 32'h0000_0000);
    send_op(ACT_FROM_INT, 32'h0123_4567, 32'h0000_0000);
    send_op(ACT_FROM_INT, 32'hffff_fffe, 32'hffff_ffff);
    send_op(ACT_UNDEF_LO, 32'h0000_0001, 32'h0000_0002);
    send_op(ACT_UNDEF_HI, 32'hffff_ffff, 32'hffff_fffe);
    drain();

    // Random bursts, most followed by a random gap or a full drain
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
        if ($urandom_range(0, 29) == 0) act = 4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        else act = 4'($urandom_range(ACT_ADD, ACT_FROM_INT));
        a = rand_operand();
        send_op(act, a, rand_partner(a));
        sent++;
      end
      if ($urandom_range(0, 24) == 0) drain();
      else if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 10));
    end

    // Let the pipeline empty out, then give it a little extra time
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.awaited_count() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.awaited_count()));
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/fpalu_pkg.sv
src/fixed_point_alu.sv
verif/fixed_point_alu_tb.sv
